// File: sv/sqllex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sqllex_pkg;

    localparam int KW_COUNT = 10;
    localparam logic [KW_COUNT-1:0] ALL_KEYWORDS = '1;

    typedef logic [4:0] kind_t;

    localparam kind_t K_IDENT   = 5'd10;
    localparam kind_t K_STRING  = 5'd11;
    localparam kind_t K_NUMBER  = 5'd12;
    localparam kind_t K_EQ      = 5'd13;
    localparam kind_t K_NE      = 5'd14;
    localparam kind_t K_LT      = 5'd15;
    localparam kind_t K_GT      = 5'd16;
    localparam kind_t K_LE      = 5'd17;
    localparam kind_t K_GE      = 5'd18;
    localparam kind_t K_COMMA   = 5'd19;
    localparam kind_t K_SEMI    = 5'd20;
    localparam kind_t K_LPAREN  = 5'd21;
    localparam kind_t K_RPAREN  = 5'd22;
    localparam kind_t K_DOT     = 5'd23;
    localparam kind_t K_STAR    = 5'd24;
    localparam kind_t K_UNKNOWN = 5'd25;
    localparam kind_t K_EOF     = 5'd26;
    localparam kind_t K_DONE    = 5'd27;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic        vld;
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  first;
        logic        done;
    } tok_t;

    typedef enum logic [5:0] {
        M_IDLE   = 6'b000001,
        M_IDENT  = 6'b000010,
        M_NUMBER = 6'b000100,
        M_STRING = 6'b001000,
        M_GT     = 6'b010000,
        M_LT     = 6'b100000
    } mode_t;

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [0:7][7:0] row;
        case (k)
            0:       row = {"SELECT", 16'h0};
            1:       row = {"FROM", 32'h0};
            2:       row = {"WHERE", 24'h0};
            3:       row = {"JOIN", 32'h0};
            4:       row = {"INNER", 24'h0};
            5:       row = {"LEFT", 32'h0};
            6:       row = {"RIGHT", 24'h0};
            7:       row = {"ON", 48'h0};
            8:       row = {"AND", 40'h0};
            9:       row = {"OR", 48'h0};
            default: row = '0;
        endcase
        return row[idx];
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        logic [2:0] len;
        case (k)
            0:       len = 3'd6;
            1:       len = 3'd4;
            2:       len = 3'd5;
            3:       len = 3'd4;
            4:       len = 3'd5;
            5:       len = 3'd4;
            6:       len = 3'd5;
            7:       len = 3'd2;
            8:       len = 3'd3;
            9:       len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? (b - 8'd32) : b;
    endfunction

    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [2:0] idx,
                                                    input logic [7:0] up);
        logic [KW_COUNT-1:0] keep;
        for (int k = 0; k < KW_COUNT; k++) begin
            keep[k] = (idx < kw_len(k)) && (up == kw_char(k, idx));
        end
        return keep;
    endfunction

    function automatic kind_t ident_kind(input logic [KW_COUNT-1:0] cand,
                                         input logic [2:0] idx);
        kind_t kind;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cand[k] && kw_len(k) == idx) begin
                kind = 5'(k);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// File: sv/sqllex_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sqllex_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] query_byte;

    modport source (output valid, output req_type, output query_byte, input ready);
    modport sink (input valid, input req_type, input query_byte, output ready);
endinterface

interface sqllex_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [7:0]  first_byte;
    logic        query_done;

    modport source (output valid, output token_kind, output start_pos,
                    output token_length, output first_byte, output query_done,
                    input ready);
    modport sink (input valid, input token_kind, input start_pos,
                  input token_length, input first_byte, input query_done,
                  output ready);
endinterface

`default_nettype wire

// File: sv/sqllex_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module sqllex_scan
    import sqllex_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       req_type,
    input  logic [7:0] query_byte,
    output tok_t       tok_a,
    output tok_t       tok_b
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] ts_reg, ts_next;
    logic [7:0]               tf_reg, tf_next;
    logic [KW_COUNT-1:0]      cand_reg, cand_next;
    logic [2:0]               idx_reg, idx_next;
    logic                     space_reg, space_next;

    logic [31:0] pos32, ts32;
    logic [7:0]  b, up;
    tok_t        fl, idl, spc, x, y, eof_tok, done_tok;
    logic        apply_idle, emit_fl;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (|v[31:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] span(input logic [31:0] from, input logic [31:0] to);
        return (to > from) ? (to - from) : 32'd0;
    endfunction

    assign pos32 = 32'(pos_reg);
    assign ts32  = 32'(ts_reg);
    assign b     = query_byte;
    assign up    = to_upper(query_byte);

    // pending token as it stands
    always_comb
    begin
        fl = '0;
        fl.start = sat16(ts32);
        fl.first = tf_reg;
        fl.len   = sat16(span(ts32, pos32));
        unique case (mode_reg)
            M_IDENT:
            begin
                fl.vld  = 1'b1;
                fl.kind = ident_kind(cand_reg, idx_reg);
            end
            M_NUMBER:
            begin
                fl.vld  = 1'b1;
                fl.kind = K_NUMBER;
            end
            M_STRING:
            begin
                fl.vld  = 1'b1;
                fl.kind = K_STRING;
                fl.len  = sat16(span(ts32 + 32'd1, pos32));
            end
            M_GT:
            begin
                fl.vld   = 1'b1;
                fl.kind  = K_GT;
                fl.len   = 16'd1;
                fl.first = CH_GT;
            end
            M_LT:
            begin
                fl.vld   = 1'b1;
                fl.kind  = K_LT;
                fl.len   = 16'd1;
                fl.first = CH_LT;
            end
            default:
            begin
                fl = '0;
            end
        endcase
    end

    // single-byte token started from idle
    always_comb
    begin
        idl       = '0;
        idl.start = sat16(pos32);
        idl.len   = 16'd1;
        idl.first = b;
        case (b)
            CH_EQ:     idl.kind = K_EQ;
            CH_COMMA:  idl.kind = K_COMMA;
            CH_SEMI:   idl.kind = K_SEMI;
            CH_LPAREN: idl.kind = K_LPAREN;
            CH_RPAREN: idl.kind = K_RPAREN;
            CH_DOT:    idl.kind = K_DOT;
            CH_STAR:   idl.kind = K_STAR;
            default:   idl.kind = K_UNKNOWN;
        endcase
        idl.vld = !(is_space(b) || is_ident_char(b) || b == CH_QUOTE
                    || b == CH_GT || b == CH_LT);
    end

    always_comb
    begin
        eof_tok       = '0;
        eof_tok.vld   = 1'b1;
        eof_tok.kind  = K_EOF;
        eof_tok.start = sat16(pos32);
        done_tok      = eof_tok;
        done_tok.kind = K_DONE;
        done_tok.done = 1'b1;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        ts_next    = ts_reg;
        tf_next    = tf_reg;
        cand_next  = cand_reg;
        idx_next   = idx_reg;
        space_next = space_reg;
        apply_idle = 1'b0;
        emit_fl    = 1'b0;
        spc        = '0;
        spc.start  = sat16(ts32);
        spc.len    = 16'd2;
        x          = '0;
        y          = '0;

        if (req_type) begin
            x = fl.vld ? fl : (space_reg ? eof_tok : done_tok);
            y = (fl.vld || space_reg) ? done_tok : '0;
            mode_next  = M_IDLE;
            pos_next   = '0;
            ts_next    = '0;
            tf_next    = '0;
            cand_next  = ALL_KEYWORDS;
            idx_next   = '0;
            space_next = 1'b0;
        end
        else begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (is_ident_char(b)) begin
                        cand_next = cand_reg & kw_keep(idx_reg, up);
                        idx_next  = (idx_reg == 3'd7) ? idx_reg : idx_reg + 3'd1;
                    end
                    else begin
                        apply_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    apply_idle = !(is_digit(b) || b == CH_DOT);
                end
                M_STRING:
                begin
                    if (b == CH_QUOTE) begin
                        emit_fl   = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (idx_reg == 3'd0) begin
                        tf_next  = b;
                        idx_next = 3'd1;
                    end
                end
                M_GT:
                begin
                    if (b == CH_EQ) begin
                        spc.vld   = 1'b1;
                        spc.kind  = K_GE;
                        spc.first = CH_GT;
                        mode_next = M_IDLE;
                    end
                    else begin
                        apply_idle = 1'b1;
                    end
                end
                M_LT:
                begin
                    if (b == CH_EQ || b == CH_GT) begin
                        spc.vld   = 1'b1;
                        spc.kind  = (b == CH_EQ) ? K_LE : K_NE;
                        spc.first = CH_LT;
                        mode_next = M_IDLE;
                    end
                    else begin
                        apply_idle = 1'b1;
                    end
                end
                default:
                begin
                    apply_idle = 1'b1;
                end
            endcase

            if (apply_idle) begin
                space_next = is_space(b);
                mode_next  = M_IDLE;
                if (!is_space(b)) begin
                    ts_next = pos_reg;
                    tf_next = b;
                    if (b == CH_QUOTE) begin
                        mode_next = M_STRING;
                        idx_next  = 3'd0;
                        tf_next   = 8'd0;
                    end
                    else if (is_digit(b)) begin
                        mode_next = M_NUMBER;
                    end
                    else if (is_alpha(b) || b == CH_UNDER) begin
                        mode_next = M_IDENT;
                        cand_next = ALL_KEYWORDS & kw_keep(3'd0, up);
                        idx_next  = 3'd1;
                    end
                    else if (b == CH_GT) begin
                        mode_next = M_GT;
                    end
                    else if (b == CH_LT) begin
                        mode_next = M_LT;
                    end
                end
            end

            x = (apply_idle || emit_fl) ? fl : spc;
            y = apply_idle ? idl : '0;
            if (!x.vld) begin
                x = y;
                y = '0;
            end
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);
        end
    end

    assign tok_a = x;
    assign tok_b = y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            ts_reg    <= '0;
            tf_reg    <= '0;
            cand_reg  <= ALL_KEYWORDS;
            idx_reg   <= '0;
            space_reg <= 1'b0;
        end
        else if (fire) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            ts_reg    <= ts_next;
            tf_reg    <= tf_next;
            cand_reg  <= cand_next;
            idx_reg   <= idx_next;
            space_reg <= space_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req_type |=> mode_reg == M_IDLE && pos_reg == '0)
        else $error("state not cleared after end of query");

    a_token_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != M_IDLE |-> !space_reg)
        else $error("space flag set inside a token");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        fire && tok_b.vld |-> tok_a.vld)
        else $error("second result without first");

endmodule

`default_nettype wire

// File: sv/sql_lexer_stream_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  role    transaction
// req      sink    one query byte (req_type 0) or end of query (req_type 1)
// tok      source  one token: kind, start, length, first byte, done flag
//
// one request per cycle enters the input register while req.ready is high, and is scanned from there
// each request yields zero, one or two tokens, pushed into a four-entry queue
// sustained rate is one request per cycle, bounded by one token out per cycle
// the scan stage waits while the queue holds more than two tokens
// rst_n clears scanner state, input register and queue; no clearing pass

module sql_lexer_stream_core
    import sqllex_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sqllex_req_if.sink   req,
    sqllex_tok_if.source tok
);

    localparam int QD = 4;

    logic       req_vld_reg;
    logic       req_type_reg;
    logic [7:0] req_byte_reg;
    logic       fire;
    tok_t       tok_a, tok_b;

    tok_t       q_reg [QD];
    logic [1:0] head_reg;
    logic [2:0] cnt_reg;
    logic [1:0] tail;
    logic       push_a, push_b, pop;

    assign fire      = req_vld_reg && (cnt_reg <= 3'd2);
    assign req.ready = !req_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_vld_reg <= 1'b0;
        end
        else if (req.ready) begin
            req_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            req_type_reg <= req.req_type;
            req_byte_reg <= req.query_byte;
        end
    end

    sqllex_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req_type   (req_type_reg),
        .query_byte (req_byte_reg),
        .tok_a      (tok_a),
        .tok_b      (tok_b)
    );

    assign push_a = fire && tok_a.vld;
    assign push_b = fire && tok_b.vld;
    assign pop    = tok.valid && tok.ready;
    assign tail   = head_reg + cnt_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else begin
            if (pop) begin
                head_reg <= head_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push_a) + 3'(push_b) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a) begin
            q_reg[tail] <= tok_a;
        end
        if (push_b) begin
            q_reg[tail + 2'd1] <= tok_b;
        end
    end

    assign tok.valid        = cnt_reg != 3'd0;
    assign tok.token_kind   = q_reg[head_reg].kind;
    assign tok.start_pos    = q_reg[head_reg].start;
    assign tok.token_length = q_reg[head_reg].len;
    assign tok.first_byte   = q_reg[head_reg].first;
    assign tok.query_done   = q_reg[head_reg].done;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(QD))
        else $error("token queue overflow");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok.valid && tok.query_done |-> tok.token_kind == K_DONE)
        else $error("done flag on a non-done token");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        req_vld_reg && !fire |=> req_vld_reg && $stable(req_byte_reg))
        else $error("input register lost a waiting request");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

import sqllex_pkg::*;

class token_checker;
    mode_t    scan;
    int       pos;
    int       tok_start;
    bit [7:0] tok_first;
    bit [9:0] cands;
    int       word_len;
    bit       after_blank;
    tok_t     expected_tokens[$];
    int       errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        scan = M_IDLE;
        pos = 0;
        tok_start = 0;
        tok_first = 8'h00;
        cands = '1;
        word_len = 0;
        after_blank = 1'b0;
    endfunction

    function string keyword_text(int k);
        case (k)
            0: return "SELECT";
            1: return "FROM";
            2: return "WHERE";
            3: return "JOIN";
            4: return "INNER";
            5: return "LEFT";
            6: return "RIGHT";
            7: return "ON";
            8: return "AND";
            9: return "OR";
            default: return "";
        endcase
    endfunction

    function bit is_blank(bit [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function bit is_num(bit [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function bit is_letter(bit [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function bit is_word(bit [7:0] b);
        return is_letter(b) || is_num(b) || b == CH_UNDER;
    endfunction

    function int gap(int from, int upto);
        return upto > from ? upto - from : 0;
    endfunction

    function void push(kind_t kind, int start, int len, bit [7:0] first, bit done);
        tok_t t;
        t.vld = 1'b1;
        t.kind = kind;
        t.start = (start > 65535) ? 16'hFFFF : 16'(start);
        t.len = (len > 65535) ? 16'hFFFF : 16'(len);
        t.first = first;
        t.done = done;
        expected_tokens = {expected_tokens, t};
    endfunction

    // narrow the keyword set by one more character, case folded
    function void take_word(bit [7:0] b);
        bit [7:0] up;
        bit [9:0] keep;
        string    w;
        up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
        keep = '0;
        for (int k = 0; k < 10; k++) begin
            w = keyword_text(k);
            if (word_len < w.len() && up == 8'(w[word_len]))
                keep[k] = 1'b1;
        end
        cands &= keep;
        if (word_len < 7)
            word_len++;
    endfunction

    function kind_t word_kind();
        for (int k = 0; k < 10; k++) begin
            if (cands[k] && keyword_text(k).len() == word_len)
                return kind_t'(k);
        end
        return K_IDENT;
    endfunction

    function void start_token(bit [7:0] b);
        kind_t kind;
        if (is_blank(b)) begin
            after_blank = 1'b1;
            return;
        end
        after_blank = 1'b0;
        tok_start = pos;
        tok_first = b;
        if (b == CH_QUOTE) begin
            scan = M_STRING;
            word_len = 0;
            tok_first = 8'h00;
            return;
        end
        if (is_num(b)) begin
            scan = M_NUMBER;
            return;
        end
        if (is_letter(b) || b == CH_UNDER) begin
            scan = M_IDENT;
            cands = '1;
            word_len = 0;
            take_word(b);
            return;
        end
        if (b == CH_GT) begin
            scan = M_GT;
            return;
        end
        if (b == CH_LT) begin
            scan = M_LT;
            return;
        end
        case (b)
            CH_EQ:     kind = K_EQ;
            CH_COMMA:  kind = K_COMMA;
            CH_SEMI:   kind = K_SEMI;
            CH_LPAREN: kind = K_LPAREN;
            CH_RPAREN: kind = K_RPAREN;
            CH_DOT:    kind = K_DOT;
            CH_STAR:   kind = K_STAR;
            default:   kind = K_UNKNOWN;
        endcase
        push(kind, tok_start, 1, b, 1'b0);
    endfunction

    function void emit_pending();
        case (scan)
            M_IDENT:  push(word_kind(), tok_start, gap(tok_start, pos), tok_first, 1'b0);
            M_NUMBER: push(K_NUMBER, tok_start, gap(tok_start, pos), tok_first, 1'b0);
            M_STRING: push(K_STRING, tok_start, gap(tok_start + 1, pos), tok_first, 1'b0);
            M_GT:     push(K_GT, tok_start, 1, CH_GT, 1'b0);
            M_LT:     push(K_LT, tok_start, 1, CH_LT, 1'b0);
            default:  ;
        endcase
        scan = M_IDLE;
    endfunction

    function void note_request(bit end_of_query, bit [7:0] b);
        if (end_of_query) begin
            emit_pending();
            if (after_blank)
                push(K_EOF, pos, 0, 8'h00, 1'b0);
            push(K_DONE, pos, 0, 8'h00, 1'b1);
            clear();
            return;
        end
        case (scan)
            M_IDENT: begin
                if (is_word(b)) begin
                    take_word(b);
                end else begin
                    emit_pending();
                    start_token(b);
                end
            end
            M_NUMBER: begin
                if (!(is_num(b) || b == CH_DOT)) begin
                    emit_pending();
                    start_token(b);
                end
            end
            M_STRING: begin
                if (b == CH_QUOTE) begin
                    push(K_STRING, tok_start, gap(tok_start + 1, pos), tok_first, 1'b0);
                    scan = M_IDLE;
                end else if (word_len == 0) begin
                    tok_first = b;
                    word_len = 1;
                end
            end
            M_GT: begin
                scan = M_IDLE;
                if (b == CH_EQ) begin
                    push(K_GE, tok_start, 2, CH_GT, 1'b0);
                end else begin
                    push(K_GT, tok_start, 1, CH_GT, 1'b0);
                    start_token(b);
                end
            end
            M_LT: begin
                scan = M_IDLE;
                if (b == CH_EQ) begin
                    push(K_LE, tok_start, 2, CH_LT, 1'b0);
                end else if (b == CH_GT) begin
                    push(K_NE, tok_start, 2, CH_LT, 1'b0);
                end else begin
                    push(K_LT, tok_start, 1, CH_LT, 1'b0);
                    start_token(b);
                end
            end
            default: begin
                scan = M_IDLE;
                start_token(b);
            end
        endcase
        if (pos < 65535)
            pos++;
    endfunction

    function int pending();
        return expected_tokens.size();
    endfunction

    task report(string msg);
        errors++;
        $display("%0t token mismatch: %s", $time, msg);
    endtask

    task check_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                     logic [7:0] first, logic done);
        tok_t e;
        if (expected_tokens.size() == 0) begin
            report($sformatf("unexpected token kind %0d start %0d", kind, start));
            return;
        end
        e = expected_tokens.pop_front();
        if (kind !== e.kind)
            report($sformatf("kind got %0d want %0d", kind, e.kind));
        if (start !== e.start)
            report($sformatf("start_pos got %0d want %0d", start, e.start));
        if (len !== e.len)
            report($sformatf("token_length got %0d want %0d", len, e.len));
        if (first !== e.first)
            report($sformatf("first_byte got %0h want %0h", first, e.first));
        if (done !== e.done)
            report($sformatf("query_done got %0b want %0b", done, e.done));
    endtask
endclass

module tb;
    typedef bit [7:0] bytes_t[$];

    logic clk;
    logic rst_n;
    int   src_idle_pct = 12;
    int   sink_idle_pct = 84;

    token_checker sb;

    sqllex_req_if req_ch();
    sqllex_tok_if tok_ch();

    sql_lexer_stream_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .tok   (tok_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        tok_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tok_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tok_ch.valid && tok_ch.ready)
            sb.check_token(tok_ch.token_kind, tok_ch.start_pos, tok_ch.token_length,
                           tok_ch.first_byte, tok_ch.query_done);
    end

    task automatic send_req(bit end_of_query, bit [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= end_of_query;
        req_ch.query_byte <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(end_of_query, b);
    endtask

    task automatic wait_all_tokens();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_query(bytes_t q, int pause_at);
        foreach (q[i])
        begin
            if (i == pause_at)
                wait_all_tokens();
            send_req(1'b0, q[i]);
        end
        send_req(1'b1, 8'($urandom));
    endtask

    function automatic void add_byte(ref bytes_t q, input bit [7:0] v);
        q = {q, v};
    endfunction

    function automatic bytes_t text_bytes(string s);
        bytes_t q;
        for (int i = 0; i < s.len(); i++)
            add_byte(q, 8'(s[i]));
        return q;
    endfunction

    function automatic bit [7:0] word_char();
        int r;
        r = $urandom_range(62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r < 62)
            return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    function automatic void add_blank(ref bytes_t q);
        repeat ($urandom_range(1, 2))
            add_byte(q, ($urandom_range(3) != 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
    endfunction

    function automatic void add_piece(ref bytes_t q);
        string    w;
        int       n;
        bit [7:0] c;
        case ($urandom_range(6))
            0: begin
                // keyword in mixed case, sometimes cut short or extended
                w = sb.keyword_text($urandom_range(9));
                n = ($urandom_range(3) == 0) ? $urandom_range(1, w.len()) : w.len();
                for (int k = 0; k < n; k++)
                begin
                    c = 8'(w[k]);
                    add_byte(q, $urandom_range(1) ? c + 8'd32 : c);
                end
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) add_byte(q, word_char());
            end
            1: begin
                add_byte(q, ($urandom_range(9) == 0) ? CH_UNDER : 8'("a" + $urandom_range(25)));
                repeat ($urandom_range(9)) add_byte(q, word_char());
            end
            2: begin
                add_byte(q, 8'("0" + $urandom_range(9)));
                repeat ($urandom_range(5))
                    add_byte(q, ($urandom_range(3) == 0) ? CH_DOT : 8'("0" + $urandom_range(9)));
            end
            3: begin
                add_byte(q, CH_QUOTE);
                repeat ($urandom_range(6))
                begin
                    do c = 8'($urandom); while (c == CH_QUOTE);
                    add_byte(q, c);
                end
                if ($urandom_range(7) != 0)
                    add_byte(q, CH_QUOTE);
            end
            4, 5: begin
                case ($urandom_range(15))
                    0: w = "=";
                    1: w = "<>";
                    2: w = "<";
                    3: w = ">";
                    4: w = "<=";
                    5: w = ">=";
                    6: w = ",";
                    7: w = ";";
                    8: w = "(";
                    9: w = ")";
                    10: w = ".";
                    11: w = "*";
                    12: w = "<<";
                    13: w = "><";
                    14: w = ">>";
                    default: w = "<<>";
                endcase
                for (int k = 0; k < w.len(); k++)
                    add_byte(q, 8'(w[k]));
            end
            default: add_byte(q, 8'($urandom));
        endcase
    endfunction

    function automatic bytes_t random_query();
        bytes_t q;
        // raw noise now and then
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(12)) add_byte(q, 8'($urandom));
            return q;
        end
        repeat ($urandom_range(8))
        begin
            add_piece(q);
            if ($urandom_range(9) < 6)
                add_blank(q);
        end
        if ($urandom_range(9) < 3)
            add_blank(q);
        return q;
    endfunction

    task automatic run_random(int target, bit pause_once);
        bytes_t q;
        int     sent;
        int     pause_at;
        sent = 0;
        while (sent < target)
        begin
            q = random_query();
            pause_at = -1;
            if (q.size() > 2 && (pause_once || $urandom_range(19) == 0))
            begin
                pause_at = $urandom_range(1, q.size() - 1);
                pause_once = 1'b0;
            end
            send_query(q, pause_at);
            sent += q.size() + 1;
        end
    endtask

    initial
    begin
        bytes_t   q;
        sb = new();
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= 1'b0;
        req_ch.query_byte <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty query, then short directed queries
        send_query(text_bytes(""), -1);
        send_query(text_bytes("a<=b "), -1);
        send_query(text_bytes("'' 'x"), -1);
        q = {8'h39, CH_DOT, 8'hFF, 8'h00, CH_GT};
        send_query(q, -1);
        send_query(text_bytes("<>"), -1);
        send_query(text_bytes("oN"), -1);
        run_random(250, 1'b0);
        wait_all_tokens();

        src_idle_pct = 84;
        sink_idle_pct = 12;
        run_random(250, 1'b1);
        wait_all_tokens();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        send_query(text_bytes("id 'it' name>=7 "), -1);
        run_random(250, 1'b0);
        wait_all_tokens();
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
